[rtl/http_date_to_epoch_seconds_core_macros.svh]
// Assertion helpers used by the checker file hdte_checker.sv.
`ifndef HTTP_DATE_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`define HTTP_DATE_TO_EPOCH_SECONDS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HDTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define HDTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/hdte_pkg.sv]
package hdte_pkg;

  // Field widths of one word on each channel
  localparam int TEXT_W  = 8;
  localparam int EPOCH_W = 39;

  // Shared multiply-accumulate unit widths
  localparam int OPA_W = 24;
  localparam int OPB_W = 18;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W = 40;

  // Body layout
  localparam logic [4:0] BODY_LAST = 5'd23;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_T     = 8'h54;

  // floor(y / 100) == (y * 5243) >> 19 for every y below 10400
  localparam logic signed [OPB_W-1:0] RECIP_100   = 18'sd5243;
  localparam int                      RECIP_SHIFT = 19;
  localparam logic signed [OPB_W-1:0] DAYS_PER_YEAR = 18'sd365;
  localparam logic signed [OPB_W-1:0] SECS_PER_DAY  = 18'sd86400;
  localparam logic signed [OPB_W-1:0] SECS_PER_HOUR = 18'sd3600;
  localparam logic signed [OPB_W-1:0] SECS_PER_MIN  = 18'sd60;
  localparam logic signed [OPB_W-1:0] COEF_POS      = 18'sd1;
  localparam logic signed [OPB_W-1:0] COEF_NEG      = -18'sd1;

  // Year is biased by 400 to stay positive: 719468 + 146097
  localparam logic signed [OPA_W-1:0] DAY_OFFSET = 24'sd865565;
  localparam logic [13:0] YEAR_BIAS    = 14'd400;
  localparam logic [13:0] YEAR_BIAS_JF = 14'd399;

  // Month names, January first, as three ASCII bytes
  localparam logic [23:0] MONTH_NAMES [12] = '{
    24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
    24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
  };

  // Day of the March-based year at the first of each month, January first
  localparam logic [8:0] MONTH_DOY_BASE [12] = '{
    9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
    9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
  };

  // Parsed fields of one date string
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } hdte_fields_t;

  // One step for the multiply-accumulate unit
  typedef struct packed {
    logic                    en;
    logic                    load;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } hdte_mac_op_t;

  // Month number 1..12 from its name, 0 when nothing matches
  function automatic logic [3:0] month_from_name(input logic [23:0] name);
    logic [3:0] m;
    m = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (name == MONTH_NAMES[i]) m = 4'(i + 1);
    end
    return m;
  endfunction

  // March-based day-of-year at the first of month m (1..12)
  function automatic logic [8:0] month_doy_base(input logic [3:0] m);
    logic [8:0] b;
    b = 9'd0;
    for (int i = 0; i < 12; i++) begin
      if (m == 4'(i + 1)) b = MONTH_DOY_BASE[i];
    end
    return b;
  endfunction

endpackage

[rtl/hdte_if.sv]
// Input channel: one string byte per word
interface hdte_in_if;
  logic                          valid;
  logic                          ready;
  logic [hdte_pkg::TEXT_W-1:0]   text_byte;
  logic                          last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// Result channel: one word per string
interface hdte_out_if;
  logic                                valid;
  logic                                ready;
  logic                                date_valid;
  logic signed [hdte_pkg::EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output date_valid, output epoch_seconds, input ready);
  modport sink   (input valid, input date_valid, input epoch_seconds, output ready);
endinterface

[rtl/hdte_parser.sv]
module hdte_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [hdte_pkg::TEXT_W-1:0] text_byte,
  input  logic                        last_byte,
  output hdte_pkg::hdte_fields_t      fields
);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_BODY   = 3'b010,
    PH_TAIL   = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        saw_comma_r, saw_comma_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        err_r, err_nxt;
  logic [15:0] letters_r, letters_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;

  logic       is_digit;
  logic       is_space;
  logic [3:0] dig;

  assign is_digit = (text_byte >= hdte_pkg::CH_ZERO) && (text_byte <= hdte_pkg::CH_NINE);
  assign is_space = (text_byte == hdte_pkg::CH_SPACE) || (text_byte == hdte_pkg::CH_TAB) ||
                    (text_byte == hdte_pkg::CH_CR) || (text_byte == hdte_pkg::CH_LF);
  assign dig = text_byte[3:0];

  // Per-byte parse step
  always_comb begin
    phase_nxt     = phase_r;
    saw_comma_nxt = saw_comma_r;
    pos_nxt       = pos_r;
    err_nxt       = err_r;
    letters_nxt   = letters_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    year_nxt      = year_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    if (fire) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (saw_comma_r && (text_byte == hdte_pkg::CH_SPACE)) begin
            phase_nxt     = PH_BODY;
            pos_nxt       = 5'd0;
            saw_comma_nxt = 1'b0;
          end else begin
            saw_comma_nxt = (text_byte == hdte_pkg::CH_COMMA);
          end
        end
        PH_BODY: begin
          unique case (pos_r)
            5'd0, 5'd1: begin
              if (!is_digit) err_nxt = 1'b1;
              else day_nxt = day_r * 7'd10 + 7'(dig);
            end
            5'd7, 5'd8, 5'd9, 5'd10: begin
              if (!is_digit) err_nxt = 1'b1;
              else year_nxt = year_r * 14'd10 + 14'(dig);
            end
            5'd12, 5'd13: begin
              if (!is_digit) err_nxt = 1'b1;
              else hour_nxt = hour_r * 7'd10 + 7'(dig);
            end
            5'd15, 5'd16: begin
              if (!is_digit) err_nxt = 1'b1;
              else min_nxt = min_r * 7'd10 + 7'(dig);
            end
            5'd18, 5'd19: begin
              if (!is_digit) err_nxt = 1'b1;
              else sec_nxt = sec_r * 7'd10 + 7'(dig);
            end
            5'd2, 5'd6, 5'd11, 5'd20: begin
              if (text_byte != hdte_pkg::CH_SPACE) err_nxt = 1'b1;
            end
            5'd14, 5'd17: begin
              if (text_byte != hdte_pkg::CH_COLON) err_nxt = 1'b1;
            end
            5'd3: letters_nxt = {text_byte, 8'h00};
            5'd4: letters_nxt = {letters_r[15:8], text_byte};
            5'd5: begin
              month_nxt = hdte_pkg::month_from_name({letters_r, text_byte});
              if (month_nxt == 4'd0) err_nxt = 1'b1;
            end
            5'd21: begin
              if (text_byte != hdte_pkg::CH_G) err_nxt = 1'b1;
            end
            5'd22: begin
              if (text_byte != hdte_pkg::CH_M) err_nxt = 1'b1;
            end
            default: begin
              if (text_byte != hdte_pkg::CH_T) err_nxt = 1'b1;
            end
          endcase
          pos_nxt = pos_r + 5'd1;
          if (pos_r >= hdte_pkg::BODY_LAST) phase_nxt = PH_TAIL;
        end
        PH_TAIL: begin
          if (!is_space) err_nxt = 1'b1;
        end
        default: phase_nxt = PH_SEARCH;
      endcase
    end
  end

  // Verdict on the final byte, taken from the updated state
  always_comb begin
    fields.ok     = fire && last_byte && (phase_nxt == PH_TAIL) && !err_nxt &&
                    (month_nxt >= 4'd1) && (month_nxt <= 4'd12) &&
                    (day_nxt >= 7'd1) && (day_nxt <= 7'd31) &&
                    (hour_nxt <= 7'd23) && (min_nxt <= 7'd59) && (sec_nxt <= 7'd60);
    fields.year   = year_nxt;
    fields.month  = month_nxt;
    fields.day    = day_nxt;
    fields.hour   = hour_nxt;
    fields.minute = min_nxt;
    fields.second = sec_nxt;
  end

  // State clears on reset and after every final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      phase_r     <= PH_SEARCH;
      saw_comma_r <= 1'b0;
      pos_r       <= 5'd0;
      err_r       <= 1'b0;
      letters_r   <= 16'd0;
      month_r     <= 4'd0;
      day_r       <= 7'd0;
      year_r      <= 14'd0;
      hour_r      <= 7'd0;
      min_r       <= 7'd0;
      sec_r       <= 7'd0;
    end else begin
      phase_r     <= phase_nxt;
      saw_comma_r <= saw_comma_nxt;
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      letters_r   <= letters_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      year_r      <= year_nxt;
      hour_r      <= hour_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
    end
  end

endmodule

[rtl/hdte_mac.sv]
module hdte_mac (
  input  logic                                clk,
  input  hdte_pkg::hdte_mac_op_t              op,
  output logic signed [hdte_pkg::ACC_W-1:0]   acc
);

  logic signed [hdte_pkg::PROD_W-1:0] prod;
  logic signed [hdte_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  // One signed product, added to the accumulator or loaded over it
  assign prod    = op.a * op.b;
  assign acc_nxt = (op.load ? '0 : acc_r) + $signed(prod[hdte_pkg::ACC_W-1:0]);

  always_ff @(posedge clk) begin
    if (op.en) acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[rtl/http_date_to_epoch_seconds_core.sv]
// Channel  Dir  Word                              Handshake
// in_if    in   text_byte[7:0], last_byte         valid/ready
// out_if   out  date_valid, epoch_seconds[38:0]   valid/ready
//
// Bytes are taken back to back while in_if.ready is high; a final byte that
// fails the checks gives its word in the next cycle. A valid date then runs
// 10 steps on the shared multiply-accumulate unit, and S_DONE registers the
// word; in_if.ready is low throughout. A byte is taken only while the result
// register is empty or draining. Synchronous active-low reset clears the
// parser and the sequencer.
module http_date_to_epoch_seconds_core (
  input logic        clk,
  input logic        rst_n,
  hdte_in_if.sink    in_if,
  hdte_out_if.source out_if
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_QUOT  = 12'b0000_0000_0010,
    S_YEAR  = 12'b0000_0000_0100,
    S_QUART = 12'b0000_0000_1000,
    S_CENT  = 12'b0000_0001_0000,
    S_QUAD  = 12'b0000_0010_0000,
    S_DOY   = 12'b0000_0100_0000,
    S_SCALE = 12'b0000_1000_0000,
    S_HOUR  = 12'b0001_0000_0000,
    S_MIN   = 12'b0010_0000_0000,
    S_SEC   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                   in_fire;
  logic                   in_rdy;
  hdte_pkg::hdte_fields_t fields;
  hdte_pkg::hdte_mac_op_t op;
  logic signed [hdte_pkg::ACC_W-1:0] acc;

  // Operands held while the sequencer runs
  logic [13:0] yb_r;
  logic [8:0]  doy_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [6:0]  q_r;

  // Result register
  logic                                out_valid_r;
  logic                                out_dv_r;
  logic signed [hdte_pkg::EPOCH_W-1:0] out_epoch_r;

  assign in_rdy      = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_if.ready = in_rdy;
  assign in_fire     = in_if.valid && in_rdy;

  hdte_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .text_byte (in_if.text_byte),
    .last_byte (in_if.last_byte),
    .fields    (fields)
  );

  hdte_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  // Sequencer: next step
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && fields.ok) state_nxt = S_QUOT;
      S_QUOT:  state_nxt = S_YEAR;
      S_YEAR:  state_nxt = S_QUART;
      S_QUART: state_nxt = S_CENT;
      S_CENT:  state_nxt = S_QUAD;
      S_QUAD:  state_nxt = S_DOY;
      S_DOY:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_HOUR;
      S_HOUR:  state_nxt = S_MIN;
      S_MIN:   state_nxt = S_SEC;
      S_SEC:   state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Operand select: days = 365Y + Y/4 - Y/100 + Y/400 + doy - offset
  always_comb begin
    op = '0;
    unique case (state_r)
      S_QUOT: begin
        op.en = 1'b1; op.load = 1'b1;
        op.a  = $signed({10'd0, yb_r}); op.b = hdte_pkg::RECIP_100;
      end
      S_YEAR: begin
        op.en = 1'b1; op.load = 1'b1;
        op.a  = $signed({10'd0, yb_r}); op.b = hdte_pkg::DAYS_PER_YEAR;
      end
      S_QUART: begin
        op.en = 1'b1;
        op.a  = $signed({12'd0, yb_r[13:2]}); op.b = hdte_pkg::COEF_POS;
      end
      S_CENT: begin
        op.en = 1'b1;
        op.a  = $signed({17'd0, q_r}); op.b = hdte_pkg::COEF_NEG;
      end
      S_QUAD: begin
        op.en = 1'b1;
        op.a  = $signed({19'd0, q_r[6:2]}); op.b = hdte_pkg::COEF_POS;
      end
      S_DOY: begin
        op.en = 1'b1;
        op.a  = $signed({15'd0, doy_r}) - hdte_pkg::DAY_OFFSET;
        op.b  = hdte_pkg::COEF_POS;
      end
      S_SCALE: begin
        op.en = 1'b1; op.load = 1'b1;
        op.a  = acc[hdte_pkg::OPA_W-1:0]; op.b = hdte_pkg::SECS_PER_DAY;
      end
      S_HOUR: begin
        op.en = 1'b1;
        op.a  = $signed({19'd0, hour_r}); op.b = hdte_pkg::SECS_PER_HOUR;
      end
      S_MIN: begin
        op.en = 1'b1;
        op.a  = $signed({18'd0, min_r}); op.b = hdte_pkg::SECS_PER_MIN;
      end
      S_SEC: begin
        op.en = 1'b1;
        op.a  = $signed({18'd0, sec_r}); op.b = hdte_pkg::COEF_POS;
      end
      S_IDLE, S_DONE: op = '0;
      default:        op = '0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) || (in_fire && in_if.last_byte && !fields.ok)) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire && fields.ok) begin
      yb_r   <= fields.year +
                ((fields.month <= 4'd2) ? hdte_pkg::YEAR_BIAS_JF : hdte_pkg::YEAR_BIAS);
      doy_r  <= hdte_pkg::month_doy_base(fields.month) + {2'd0, fields.day} - 9'd1;
      hour_r <= fields.hour[4:0];
      min_r  <= fields.minute[5:0];
      sec_r  <= fields.second[5:0];
    end
    // quotient by 100 comes out of the first product
    if (state_r == S_YEAR) q_r <= acc[hdte_pkg::RECIP_SHIFT +: 7];
    if (state_r == S_DONE) begin
      out_dv_r    <= 1'b1;
      out_epoch_r <= acc[hdte_pkg::EPOCH_W-1:0];
    end else if (in_fire && in_if.last_byte && !fields.ok) begin
      out_dv_r    <= 1'b0;
      out_epoch_r <= '0;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.date_valid    = out_dv_r;
  assign out_if.epoch_seconds = out_epoch_r;

endmodule

[rtl/hdte_checker.sv]
`include "http_date_to_epoch_seconds_core_macros.svh"

module hdte_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_last_byte,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_date_valid,
  input logic signed [hdte_pkg::EPOCH_W-1:0] out_epoch_seconds
);

  // A rejected string reports zero seconds
  `HDTE_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && !out_date_valid, out_epoch_seconds == '0)

  // A valid date lies between year 0 and the end of year 9999
  `HDTE_ASSERT_NOW(a_valid_range, clk, rst_n, out_valid && out_date_valid, (out_epoch_seconds >= -39'sd62167219200) && (out_epoch_seconds <= 39'sd253402300800))

  // After a final byte the core is either busy or already holding its word
  `HDTE_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_valid && in_ready && in_last_byte, out_valid || !in_ready)

  // A stalled word holds
  `HDTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_date_valid) && $stable(out_epoch_seconds))

endmodule

bind http_date_to_epoch_seconds_core hdte_checker u_hdte_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_last_byte      (in_if.last_byte),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_date_valid    (out_if.date_valid),
  .out_epoch_seconds (out_if.epoch_seconds)
);

[tb/http_date_to_epoch_seconds_core_checker.sv]
// Watches both channels, predicts each date word and compares it.
module http_date_to_epoch_seconds_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  hdte_in_if          in_ch,
  hdte_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned dates_pending
);

  typedef enum logic [1:0] {SEEK_COMMA, IN_BODY, IN_TRAILER} scan_phase_e;

  typedef struct {
    bit          ok;
    logic [38:0] secs;
  } epoch_word_t;

  localparam int unsigned BODY_BYTES = 24;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam string MONTH_ABBREV = "JanFebMarAprMayJunJulAugSepOctNovDec";

  // parser state
  scan_phase_e phase;
  bit          comma_seen;
  int unsigned body_pos;
  bit          layout_bad;
  logic [7:0]  mon_hi, mon_lo;
  logic [3:0]  mon_num;
  logic [6:0]  day_acc, hour_acc, min_acc, sec_acc;
  logic [13:0] year_acc;

  epoch_word_t expected_dates[$];

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // proleptic Gregorian day count relative to 1970-01-01
  function automatic longint civil_days(input longint yr, input int unsigned mo,
                                        input int unsigned dy);
    longint era, yoe, doy, doe;
    if (mo <= 2) yr = yr - 1;
    era = (yr >= 0 ? yr : yr - 399) / 400;
    yoe = yr - era * 400;
    doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic clear_parse();
    phase      = SEEK_COMMA;
    comma_seen = 0;
    body_pos   = 0;
    layout_bad = 0;
    mon_hi     = '0;
    mon_lo     = '0;
    mon_num    = '0;
    day_acc    = '0;
    year_acc   = '0;
    hour_acc   = '0;
    min_acc    = '0;
    sec_acc    = '0;
  endtask

  // one byte of the fixed 24-byte body
  task automatic body_field(input logic [7:0] c);
    case (body_pos)
      0, 1: begin
        if (is_digit(c)) day_acc = 7'(day_acc * 10 + (c - CH_0));
        else layout_bad = 1;
      end
      7, 8, 9, 10: begin
        if (is_digit(c)) year_acc = 14'(year_acc * 10 + (c - CH_0));
        else layout_bad = 1;
      end
      12, 13: begin
        if (is_digit(c)) hour_acc = 7'(hour_acc * 10 + (c - CH_0));
        else layout_bad = 1;
      end
      15, 16: begin
        if (is_digit(c)) min_acc = 7'(min_acc * 10 + (c - CH_0));
        else layout_bad = 1;
      end
      18, 19: begin
        if (is_digit(c)) sec_acc = 7'(sec_acc * 10 + (c - CH_0));
        else layout_bad = 1;
      end
      2, 6, 11, 20: if (c != CH_SP) layout_bad = 1;
      14, 17:       if (c != CH_COLON) layout_bad = 1;
      3: mon_hi = c;
      4: mon_lo = c;
      5: begin
        mon_num = '0;
        for (int i = 0; i < 12; i++) begin
          if (MONTH_ABBREV[3*i] == mon_hi && MONTH_ABBREV[3*i+1] == mon_lo &&
              MONTH_ABBREV[3*i+2] == c)
            mon_num = 4'(i + 1);
        end
        if (mon_num == 0) layout_bad = 1;
      end
      21: if (c != "G") layout_bad = 1;
      22: if (c != "M") layout_bad = 1;
      default: if (c != "T") layout_bad = 1;
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] c);
    case (phase)
      SEEK_COMMA: begin
        if (comma_seen && c == CH_SP) begin
          phase      = IN_BODY;
          body_pos   = 0;
          comma_seen = 0;
        end else begin
          comma_seen = (c == CH_COMMA);
        end
      end
      IN_BODY: begin
        body_field(c);
        body_pos++;
        if (body_pos >= BODY_BYTES) phase = IN_TRAILER;
      end
      default: if (!is_blank(c)) layout_bad = 1;
    endcase
  endtask

  // close out the string: queue the expected word and start over
  task automatic finish_date();
    epoch_word_t w;
    longint      s;
    w.ok = phase == IN_TRAILER && !layout_bad && mon_num >= 1 && mon_num <= 12 &&
           day_acc >= 1 && day_acc <= 31 && hour_acc <= 23 && min_acc <= 59 &&
           sec_acc <= 60;
    s = 0;
    if (w.ok)
      s = civil_days(longint'(year_acc), mon_num, day_acc) * 86400 +
          longint'(hour_acc) * 3600 + longint'(min_acc) * 60 + longint'(sec_acc);
    w.secs = s[38:0];
    expected_dates.push_back(w);
    clear_parse();
  endtask

  initial begin
    mismatch_count = 0;
    dates_pending  = 0;
    clear_parse();
  end

  // result side first: a word leaving now never belongs to a byte taken now
  always @(posedge clk) begin
    epoch_word_t want;
    if (!rst_n) begin
      clear_parse();
      expected_dates.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word: expected none, got valid %0b seconds %0d",
                   $time, out_ch.date_valid, $signed(out_ch.epoch_seconds));
        end else begin
          want = expected_dates.pop_front();
          if (out_ch.date_valid !== want.ok) begin
            mismatch_count++;
            $display("%0t: date_valid mismatch: expected %0b, got %0b",
                     $time, want.ok, out_ch.date_valid);
          end
          if (out_ch.epoch_seconds !== want.secs) begin
            mismatch_count++;
            $display("%0t: epoch_seconds mismatch: expected %0d, got %0d",
                     $time, $signed(want.secs), $signed(out_ch.epoch_seconds));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(in_ch.text_byte);
        if (in_ch.last_byte) finish_date();
      end
    end
    dates_pending = expected_dates.size();
  end

endmodule

[tb/http_date_to_epoch_seconds_core_test.sv]
// Stimulus and verdict for the HTTP date parser.
module http_date_to_epoch_seconds_core_test;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned BYTE_TARGET  = 1900;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam string MONTH_ABBREV = "JanFebMarAprMayJunJulAugSepOctNovDec";
  localparam string DAY_ABBREV   = "SunMonTueWedThuFriSat";

  logic clk;
  logic rst_n;

  hdte_in_if  in_ch();
  hdte_out_if out_ch();

  int unsigned mismatch_count;
  int unsigned dates_pending;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          send_steady;
  bit          drain_steady;
  bit          paused;
  logic [7:0]  line_buf[$];

  http_date_to_epoch_seconds_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  http_date_to_epoch_seconds_core_checker date_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatch_count(mismatch_count),
    .dates_pending (dates_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one byte word, offered after a random gap (none when steady), held until taken
  task automatic send_byte(input logic [7:0] b, input bit is_last);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.text_byte = b;
    in_ch.last_byte = is_last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int unsigned v, input int unsigned n);
    int unsigned p;
    for (int k = n; k > 0; k--) begin
      p = 1;
      repeat (k - 1) p = p * 10;
      line_buf.push_back(8'("0" + (v / p) % 10));
    end
  endtask

  // hold the sender until every expected word has drained
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (dates_pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // mostly well-formed date with random fields, sometimes damaged
  task automatic build_date_line();
    int unsigned mon, k, pos, cut;
    line_buf.delete();
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        k = $urandom_range(0, 6);
        add_text(DAY_ABBREV.substr(3 * k, 3 * k + 2));
      end
      2: repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
      default: add_text("x,y,,");
    endcase
    add_text(", ");
    add_digits(($urandom_range(0, 15) == 0) ? $urandom_range(0, 99)
                                            : $urandom_range(1, 31), 2);
    add_text(" ");
    mon = $urandom_range(0, 11);
    add_text(MONTH_ABBREV.substr(3 * mon, 3 * mon + 2));
    if ($urandom_range(0, 11) == 0) begin
      pos = line_buf.size() - 1 - $urandom_range(0, 2);
      line_buf[pos] = line_buf[pos] ^ 8'h20;
    end
    add_text(" ");
    case ($urandom_range(0, 7))
      0:       add_digits(0, 4);
      1:       add_digits(9999, 4);
      default: add_digits($urandom_range(0, 9999), 4);
    endcase
    add_text(" ");
    add_digits(($urandom_range(0, 15) == 0) ? $urandom_range(0, 99)
                                            : $urandom_range(0, 23), 2);
    add_text(":");
    add_digits(($urandom_range(0, 15) == 0) ? $urandom_range(0, 99)
                                            : $urandom_range(0, 59), 2);
    add_text(":");
    add_digits(($urandom_range(0, 15) == 0) ? $urandom_range(0, 99)
                                            : $urandom_range(0, 60), 2);
    add_text(" GMT");
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0:       line_buf.push_back(8'h20);
        1:       line_buf.push_back(8'h09);
        2:       line_buf.push_back(8'h0D);
        default: line_buf.push_back(8'h0A);
      endcase
    end
    // damage: one byte replaced, cut short, or junk on the end
    case ($urandom_range(0, 7))
      0: begin
        pos = $urandom_range(0, line_buf.size() - 1);
        line_buf[pos] = 8'($urandom_range(0, 255));
      end
      1: begin
        cut = $urandom_range(1, line_buf.size() - 1);
        while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
      2: line_buf.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // receiver: random stalls, steady stretches, two long hold-offs
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ch.ready = 1'b0;
    drain_steady = 0;
    taken = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) drain_steady = !drain_steady;
      stall = drain_steady ? 0 : $urandom_range(0, 7);
      if (taken == 6 || taken == 40) stall = 300;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  // sender
  initial begin
    string directed_lines[$];
    in_ch.valid     = 1'b0;
    in_ch.text_byte = '0;
    in_ch.last_byte = 1'b0;
    rst_n       = 1'b0;
    send_steady = 0;
    paused      = 0;
    bytes_sent  = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // extremes of the date range, the epoch itself, and malformed strings of many kinds
    directed_lines = '{
      ", 01 Jan 0000 00:00:00 GMT",
      "Fri, 31 Dec 9999 23:59:60 GMT\015\012\011 ",
      "Thu, 01 Jan 1970 00:00:00 GMT",
      "Sun, 06 Nov 1994 08:49:37 GMT",
      "Wed, 31 Feb 2023 12:00:00 GMT",
      "no comma here",
      "Mon, 29 Feb 2000 12",
      "Tue, 15 Mar 2022 10:00:00 GMTx",
      "Wed,  01 Jan 2020 00:00:00 GMT",
      ", 00 Jan 2020 00:00:00 GMT",
      ", 32 Feb 1999 00:00:00 GMT",
      ", 15 Apr 2001 24:00:00 GMT",
      ", 15 May 2001 23:60:00 GMT",
      ", 15 Jun 2001 23:59:61 GMT",
      ", 01 jan 2000 00:00:00 GMT",
      ", 01 Jan 2000 00-00:00 UTC",
      "a,b, 1x Jan 2000 00:00:00 GMT"
    };
    foreach (directed_lines[i]) begin
      line_buf.delete();
      add_text(directed_lines[i]);
      send_line();
    end
    line_buf = '{8'h00, 8'hFF};
    send_line();
    line_buf = '{8'hFF};
    send_line();
    wait_drained();

    // random strings, with one full drain halfway
    while (bytes_sent < BYTE_TARGET) begin
      send_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        line_buf.delete();
        repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_date_line();
      end
      send_line();
      if (!paused && bytes_sent >= BYTE_TARGET / 2) begin
        paused = 1;
        wait_drained();
      end
    end

    wait_drained();
    if (mismatch_count == 0 && dates_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
